// ===== rtl/stok_pkg.sv =====
// stok_pkg: token kinds, scan modes, keyword table and character classes
// shared by the source tokenizer; no dependencies
`default_nettype none

package stok_pkg;

    // token kind codes
    localparam logic [5:0] KIND_END    = 6'd0;
    localparam logic [5:0] KIND_IDENT  = 6'd1;
    localparam logic [5:0] KIND_NUMBER = 6'd2;
    localparam logic [5:0] KIND_STRING = 6'd3;
    localparam logic [5:0] KIND_FN     = 6'd4;
    localparam logic [5:0] KIND_LET    = 6'd5;
    localparam logic [5:0] KIND_IF     = 6'd6;
    localparam logic [5:0] KIND_ELSE   = 6'd7;
    localparam logic [5:0] KIND_WHILE  = 6'd8;
    localparam logic [5:0] KIND_RETURN = 6'd10;
    localparam logic [5:0] KIND_LPAREN = 6'd12;
    localparam logic [5:0] KIND_RPAREN = 6'd13;
    localparam logic [5:0] KIND_LBRACE = 6'd14;
    localparam logic [5:0] KIND_RBRACE = 6'd15;
    localparam logic [5:0] KIND_SEMI   = 6'd16;
    localparam logic [5:0] KIND_COLON  = 6'd17;
    localparam logic [5:0] KIND_COMMA  = 6'd18;
    localparam logic [5:0] KIND_PLUS   = 6'd19;
    localparam logic [5:0] KIND_MINUS  = 6'd20;
    localparam logic [5:0] KIND_STAR   = 6'd21;
    localparam logic [5:0] KIND_SLASH  = 6'd22;
    localparam logic [5:0] KIND_ASSIGN = 6'd23;
    localparam logic [5:0] KIND_EQ     = 6'd24;
    localparam logic [5:0] KIND_NE     = 6'd25;
    localparam logic [5:0] KIND_LT     = 6'd26;
    localparam logic [5:0] KIND_GT     = 6'd27;
    localparam logic [5:0] KIND_LE     = 6'd28;
    localparam logic [5:0] KIND_GE     = 6'd29;
    localparam logic [5:0] KIND_AND    = 6'd30;
    localparam logic [5:0] KIND_OR     = 6'd31;
    localparam logic [5:0] KIND_ARROW  = 6'd32;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    // keyword table: length, packed bytes (first byte highest), kind
    localparam int KW_COUNT = 6;
    localparam logic [2:0]  KW_LEN  [KW_COUNT] = '{3'd2, 3'd3, 3'd2, 3'd4, 3'd5, 3'd6};
    localparam logic [47:0] KW_WORD [KW_COUNT] = '{
        48'h0000_0000_666E, 48'h0000_006C_6574, 48'h0000_0000_6966,
        48'h0000_656C_7365, 48'h0077_6869_6C65, 48'h7265_7475_726E};
    localparam logic [5:0]  KW_KIND [KW_COUNT] = '{
        KIND_FN, KIND_LET, KIND_IF, KIND_ELSE, KIND_WHILE, KIND_RETURN};

    // scan modes, one-hot
    typedef enum logic [7:0] {
        MODE_IDLE    = 8'b0000_0001,
        MODE_IDENT   = 8'b0000_0010,
        MODE_NUMBER  = 8'b0000_0100,
        MODE_STRING  = 8'b0000_1000,
        MODE_ESCAPE  = 8'b0001_0000,
        MODE_COMMENT = 8'b0010_0000,
        MODE_SLASH   = 8'b0100_0000,
        MODE_OPER    = 8'b1000_0000
    } mode_t;

    // one result word
    typedef struct packed {
        logic        last;
        logic [15:0] column;
        logic [15:0] line;
        logic [15:0] length;
        logic [15:0] start;
        logic [5:0]  kind;
    } token_t;

    // output queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = c >= 8'h30 && c <= 8'h39;
    endfunction

    // kind of a byte that is a token on its own, end kind if none
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        unique case (c)
            CH_LPAREN: single_kind = KIND_LPAREN;
            CH_RPAREN: single_kind = KIND_RPAREN;
            CH_LBRACE: single_kind = KIND_LBRACE;
            CH_RBRACE: single_kind = KIND_RBRACE;
            CH_SEMI:   single_kind = KIND_SEMI;
            CH_COLON:  single_kind = KIND_COLON;
            CH_COMMA:  single_kind = KIND_COMMA;
            CH_PLUS:   single_kind = KIND_PLUS;
            CH_STAR:   single_kind = KIND_STAR;
            default:   single_kind = KIND_END;
        endcase
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        is_op_start = c == CH_EQUAL || c == CH_LT || c == CH_GT || c == CH_BANG
                   || c == CH_AMP || c == CH_BAR || c == CH_MINUS;
    endfunction

    // kind of a pending operator standing alone; end kind for ! & |
    function automatic logic [5:0] lone_kind(input logic [7:0] op);
        unique case (op)
            CH_EQUAL: lone_kind = KIND_ASSIGN;
            CH_LT:    lone_kind = KIND_LT;
            CH_GT:    lone_kind = KIND_GT;
            CH_MINUS: lone_kind = KIND_MINUS;
            default:  lone_kind = KIND_END;
        endcase
    endfunction

    // kind of a two-byte operator, end kind when not completed
    function automatic logic [5:0] pair_kind(input logic [7:0] op, input logic [7:0] c);
        priority if (op == CH_EQUAL && c == CH_EQUAL) pair_kind = KIND_EQ;
        else if (op == CH_BANG && c == CH_EQUAL)      pair_kind = KIND_NE;
        else if (op == CH_LT && c == CH_EQUAL)        pair_kind = KIND_LE;
        else if (op == CH_GT && c == CH_EQUAL)        pair_kind = KIND_GE;
        else if (op == CH_AMP && c == CH_AMP)         pair_kind = KIND_AND;
        else if (op == CH_BAR && c == CH_BAR)         pair_kind = KIND_OR;
        else if (op == CH_MINUS && c == CH_GT)        pair_kind = KIND_ARROW;
        else                                          pair_kind = KIND_END;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/source_tokenizer.sv =====
// source_tokenizer: byte-stream lexer with a four-word token queue
// depends on stok_pkg
`default_nettype none

//  channel   dir  tdata                                         tuser  tlast
//  s_axis    in   ch[7:0]                                       -      at_end
//  m_axis    out  kind, start, length, line, column, 2 pad      -      last_token
//
//  one source byte is taken per cycle unless stalled; the scan state updates in the same
//  cycle and the up to two tokens it yields are written to a four-word queue
//  s_axis_tready is high while the queue has room for two words, so input
//  stalls only when the output side holds back or a byte yields two tokens
//  m_axis words come straight from the queue head, one per cycle while m_axis_tready is high
//  rst_n clears the scan state and empties the queue

module source_tokenizer #(
    parameter int COUNTER_WIDTH = 16
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [7:0]             s_axis_tdata,   // [7:0] ch
    input  wire                    s_axis_tlast,   // at_end
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [5:0] token_kind, [21:6] start_offset, [37:22] token_length,
    // [53:38] line_number, [69:54] column_number, [71:70] zero
    output logic [71:0]            m_axis_tdata,
    output logic                   m_axis_tlast    // last_token
);
    import stok_pkg::*;

    localparam int CW = COUNTER_WIDTH;
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

    function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
        inc_sat = (v == CNT_MAX) ? v : v + CNT_ONE;
    endfunction

    function automatic logic [15:0] sat16(input logic [CW-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        sat16 = (w > 33'h0_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    // scan state
    mode_t          mode_reg, mode_next;
    logic [7:0]     pend_op_reg, pend_op_next;
    logic [CW-1:0]  tok_start_reg, tok_start_next;
    logic [CW-1:0]  tok_line_reg, tok_line_next;
    logic [CW-1:0]  tok_col_reg, tok_col_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [CW-1:0]  line_reg, line_next;
    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  run_len_reg, run_len_next;
    logic [47:0]    prefix_reg, prefix_next;
    logic           finished_reg, finished_next;

    // token emission
    logic           emit_pend, emit_here, do_fresh;
    logic [5:0]     pend_kind, here_kind, ident_kind, lone_k, pair_k;
    logic [CW-1:0]  pend_len;
    token_t         pend_tok, here_tok;
    logic [7:0]     c;
    logic           accept;

    // output queue
    token_t                queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [1:0]            push_cnt;
    logic                  pop;

    assign c      = s_axis_tdata;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign lone_k = lone_kind(pend_op_reg);
    assign pair_k = pair_kind(pend_op_reg, c);

    // keyword lookup on the finished identifier
    always_comb
    begin
        ident_kind = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (run_len_reg == CW'(KW_LEN[i]) && prefix_reg == KW_WORD[i])
                ident_kind = KW_KIND[i];
        end
    end

    // next scan state and emitted tokens
    always_comb
    begin
        mode_next      = mode_reg;
        pend_op_next   = pend_op_reg;
        tok_start_next = tok_start_reg;
        tok_line_next  = tok_line_reg;
        tok_col_next   = tok_col_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        run_len_next   = run_len_reg;
        prefix_next    = prefix_reg;
        finished_next  = finished_reg;
        emit_pend      = 1'b0;
        emit_here      = 1'b0;
        do_fresh       = 1'b0;
        pend_kind      = KIND_END;
        pend_len       = run_len_reg;
        here_kind      = KIND_END;

        if (s_axis_tlast)
        begin
            // end of source: unless finished, flush pending token and end token; then reset
            if (!finished_reg)
            begin
                emit_here = 1'b1;
                unique case (mode_reg)
                    MODE_IDENT:
                    begin
                        emit_pend = 1'b1;
                        pend_kind = ident_kind;
                    end
                    MODE_NUMBER:
                    begin
                        emit_pend = 1'b1;
                        pend_kind = KIND_NUMBER;
                    end
                    MODE_STRING, MODE_ESCAPE:
                    begin
                        emit_pend = 1'b1;
                        pend_kind = KIND_STRING;
                    end
                    MODE_SLASH:
                    begin
                        emit_pend = 1'b1;
                        pend_kind = KIND_SLASH;
                        pend_len  = CNT_ONE;
                    end
                    MODE_OPER:
                    begin
                        emit_pend = 1'b1;
                        pend_kind = lone_k;
                        pend_len  = CNT_ONE;
                        emit_here = lone_k != KIND_END;
                    end
                    default: ;
                endcase
            end
            mode_next      = MODE_IDLE;
            pend_op_next   = 8'd0;
            tok_start_next = '0;
            tok_line_next  = CNT_ONE;
            tok_col_next   = CNT_ONE;
            pos_next       = '0;
            line_next      = CNT_ONE;
            col_next       = CNT_ONE;
            run_len_next   = '0;
            prefix_next    = '0;
            finished_next  = 1'b0;
        end
        else if (!finished_reg)
        begin
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c))
                    begin
                        if (run_len_reg < CW'(6))
                            prefix_next = {prefix_reg[39:0], c};
                        run_len_next = inc_sat(run_len_reg);
                        pos_next     = inc_sat(pos_reg);
                        col_next     = inc_sat(col_reg);
                    end
                    else
                    begin
                        emit_pend = 1'b1;
                        pend_kind = ident_kind;
                        do_fresh  = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (is_digit(c))
                    begin
                        run_len_next = inc_sat(run_len_reg);
                        pos_next     = inc_sat(pos_reg);
                        col_next     = inc_sat(col_reg);
                    end
                    else
                    begin
                        emit_pend = 1'b1;
                        pend_kind = KIND_NUMBER;
                        do_fresh  = 1'b1;
                    end
                end
                MODE_STRING, MODE_ESCAPE:
                begin
                    if (c == CH_NUL)
                    begin
                        emit_pend     = 1'b1;
                        pend_kind     = KIND_STRING;
                        emit_here     = 1'b1;
                        finished_next = 1'b1;
                    end
                    else
                    begin
                        // newline inside a string moves the column only
                        run_len_next = inc_sat(run_len_reg);
                        pos_next     = inc_sat(pos_reg);
                        col_next     = inc_sat(col_reg);
                        if (mode_reg == MODE_ESCAPE)
                            mode_next = MODE_STRING;
                        else if (c == CH_BSLASH)
                            mode_next = MODE_ESCAPE;
                        else if (c == CH_QUOTE)
                        begin
                            emit_pend = 1'b1;
                            pend_kind = KIND_STRING;
                            pend_len  = inc_sat(run_len_reg);
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF || c == CH_NUL)
                        do_fresh = 1'b1;
                    else
                    begin
                        pos_next = inc_sat(pos_reg);
                        col_next = inc_sat(col_reg);
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        pos_next  = inc_sat(pos_reg);
                        col_next  = inc_sat(col_reg);
                    end
                    else
                    begin
                        emit_pend = 1'b1;
                        pend_kind = KIND_SLASH;
                        pend_len  = CNT_ONE;
                        do_fresh  = 1'b1;
                    end
                end
                MODE_OPER:
                begin
                    emit_pend = 1'b1;
                    if (pair_k != KIND_END)
                    begin
                        pend_kind = pair_k;
                        pend_len  = CW'(2);
                        mode_next = MODE_IDLE;
                        pos_next  = inc_sat(pos_reg);
                        col_next  = inc_sat(col_reg);
                    end
                    else
                    begin
                        pend_kind = lone_k;
                        pend_len  = CNT_ONE;
                        if (lone_k == KIND_END)
                        begin
                            // lone ! & or | closes the run, this byte dropped
                            finished_next = 1'b1;
                            mode_next     = MODE_IDLE;
                        end
                        else
                            do_fresh = 1'b1;
                    end
                end
                default: do_fresh = 1'b1;
            endcase

            // lex the byte as the start of a new token
            if (do_fresh)
            begin
                mode_next = MODE_IDLE;
                if (c == CH_NUL)
                begin
                    emit_here     = 1'b1;
                    finished_next = 1'b1;
                end
                else if (c == CH_SPACE || c == CH_TAB || c == CH_CR)
                begin
                    pos_next = inc_sat(pos_reg);
                    col_next = inc_sat(col_reg);
                end
                else if (c == CH_LF)
                begin
                    line_next = inc_sat(line_reg);
                    col_next  = CNT_ONE;
                    pos_next  = inc_sat(pos_reg);
                end
                else if (single_kind(c) != KIND_END)
                begin
                    emit_here = 1'b1;
                    here_kind = single_kind(c);
                    pos_next  = inc_sat(pos_reg);
                    col_next  = inc_sat(col_reg);
                end
                else if (is_alpha(c) || is_digit(c) || c == CH_QUOTE || c == CH_SLASH
                         || is_op_start(c))
                begin
                    tok_start_next = pos_reg;
                    tok_line_next  = line_reg;
                    tok_col_next   = col_reg;
                    run_len_next   = CNT_ONE;
                    pos_next       = inc_sat(pos_reg);
                    col_next       = inc_sat(col_reg);
                    if (is_alpha(c))
                    begin
                        prefix_next = {40'd0, c};
                        mode_next   = MODE_IDENT;
                    end
                    else if (is_digit(c))
                        mode_next = MODE_NUMBER;
                    else if (c == CH_QUOTE)
                        mode_next = MODE_STRING;
                    else if (c == CH_SLASH)
                        mode_next = MODE_SLASH;
                    else
                    begin
                        pend_op_next = c;
                        mode_next    = MODE_OPER;
                    end
                end
                else
                begin
                    emit_here     = 1'b1;
                    finished_next = 1'b1;
                end
            end
        end
    end

    // token words
    always_comb
    begin
        pend_tok.kind   = pend_kind;
        pend_tok.start  = sat16(tok_start_reg);
        pend_tok.length = (pend_kind == KIND_END) ? 16'd0 : sat16(pend_len);
        pend_tok.line   = sat16(tok_line_reg);
        pend_tok.column = sat16(tok_col_reg);
        pend_tok.last   = pend_kind == KIND_END;

        here_tok.kind   = here_kind;
        here_tok.start  = sat16(pos_reg);
        here_tok.length = (here_kind == KIND_END) ? 16'd0 : 16'd1;
        here_tok.line   = sat16(line_reg);
        here_tok.column = sat16(col_reg);
        here_tok.last   = here_kind == KIND_END;
    end

    // scan state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pend_op_reg   <= 8'd0;
            tok_start_reg <= '0;
            tok_line_reg  <= CNT_ONE;
            tok_col_reg   <= CNT_ONE;
            pos_reg       <= '0;
            line_reg      <= CNT_ONE;
            col_reg       <= CNT_ONE;
            run_len_reg   <= '0;
            prefix_reg    <= '0;
            finished_reg  <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            pend_op_reg   <= pend_op_next;
            tok_start_reg <= tok_start_next;
            tok_line_reg  <= tok_line_next;
            tok_col_reg   <= tok_col_next;
            pos_reg       <= pos_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            run_len_reg   <= run_len_next;
            prefix_reg    <= prefix_next;
            finished_reg  <= finished_next;
        end
    end

    // queue handshake
    assign s_axis_tready = count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2);
    assign m_axis_tvalid = count_reg != '0;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign push_cnt      = accept ? (2'(emit_pend) + 2'(emit_here)) : 2'd0;

    // queue pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + QUEUE_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(pop);
            count_reg  <= count_reg + (QUEUE_AW+1)'(push_cnt) - (QUEUE_AW+1)'(pop);
        end
    end

    // queue storage, pending token goes first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (emit_pend)
            begin
                queue_reg[wr_ptr_reg] <= pend_tok;
                if (emit_here)
                    queue_reg[wr_ptr_reg + QUEUE_AW'(1)] <= here_tok;
            end
            else if (emit_here)
                queue_reg[wr_ptr_reg] <= here_tok;
        end
    end

    // output word
    always_comb
    begin
        m_axis_tdata = {2'b00, queue_reg[rd_ptr_reg].column, queue_reg[rd_ptr_reg].line,
                        queue_reg[rd_ptr_reg].length, queue_reg[rd_ptr_reg].start,
                        queue_reg[rd_ptr_reg].kind};
        m_axis_tlast = queue_reg[rd_ptr_reg].last;
    end

endmodule

`default_nettype wire
